// ===== rtl/cjk_font_code_address_unit_defines.svh =====
// assertion macros for the font address unit and its checker
`ifndef CJK_FONT_CODE_ADDRESS_UNIT_DEFINES_SVH
`define CJK_FONT_CODE_ADDRESS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CFAU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfau same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define CFAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfau next-cycle check failed");

`endif

// ===== rtl/cfau_pkg.sv =====
package cfau_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int SUB_W      = 17;
	localparam int GBK_SPANS  = 4;
	localparam int GB_SPANS   = 20;
	localparam int PER_W      = 14;
	localparam int IDX_W      = 15;
	localparam int PROD_W     = PER_W + IDX_W;

	typedef enum logic {
		OP_TABLE = 1'b0,
		OP_GLYPH = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE         = 2'd0,
		REG_TABLE_BASE   = 2'd1,
		REG_GLYPH_BASE   = 2'd2,
		REG_GLYPH_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] code;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] byte_address;
	} rsp_t;

	typedef struct packed {
		logic        gb2312_mode;
		logic [31:0] table_base;
		logic [31:0] glyph_base;
		logic [7:0]  glyph_height;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      lo;
		logic [15:0]      hi;
		logic [SUB_W-1:0] sub;
	} span_t;

	localparam span_t GBK_SPAN_TAB [GBK_SPANS] = '{
		'{16'h0000, 16'h047F, 17'd0},
		'{16'h2000, 16'h33FF, 17'd14080},
		'{16'h4E00, 16'h9FFF, 17'd27392},
		'{16'hF900, 16'hFFFF, 17'd68608}
	};

	localparam span_t GB_SPAN_TAB [GB_SPANS] = '{
		'{16'h00A4, 16'h02C9, 17'd328},
		'{16'h0391, 16'h0451, 17'd726},
		'{16'h2014, 16'h203B, 17'd14938},
		'{16'h2103, 16'h2312, 17'd15336},
		'{16'h2460, 16'h2642, 17'd16002},
		'{16'h3000, 16'h3129, 17'd20988},
		'{16'h3220, 16'h3229, 17'd21480},
		'{16'h4E00, 16'h7DAE, 17'd35732},
		'{16'h7E3B, 16'h8C98, 17'd36012},
		'{16'h8D1D, 16'h8ECE, 17'd36276},
		'{16'h8F66, 16'h91DC, 17'd36578},
		'{16'h9274, 16'h99A8, 17'd36880},
		'{16'h9A6C, 16'h9B54, 17'd37270},
		'{16'h9C7C, 16'h9CE2, 17'd37860},
		'{16'h9E1F, 16'h9FA0, 17'd38492},
		'{16'hE000, 16'hE233, 17'd71450},
		'{16'hE766, 16'hE814, 17'd74110},
		'{16'hFE31, 16'hFE44, 17'd85430},
		'{16'hFF01, 16'hFF5E, 17'd85806},
		'{16'hFFE0, 16'hFFFF, 17'd86064}
	};

	localparam logic [7:0]  GBK_ROW_LEN   = 8'd191;
	localparam logic [7:0]  GB_ROW_LEN    = 8'd94;
	localparam logic [7:0]  GBK_HI_MIN    = 8'h81;
	localparam logic [7:0]  GBK_LO_MIN    = 8'h40;
	localparam logic [7:0]  GB_BYTE_MIN   = 8'hA1;
	localparam logic [7:0]  GB_HI_MAX     = 8'hF7;
	localparam logic [7:0]  BYTE_BAD      = 8'hFF;
	localparam logic [31:0] GLYPH_HDR     = 32'd6;
	localparam logic [7:0]  HEIGHT_RESET  = 8'd16;

endpackage

// ===== rtl/cjk_font_code_address_unit.sv =====
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | opcode, code
// rsp     | out       | rsp_valid / rsp_ready | hit, byte_address
// cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// one item per cycle while the skid register is empty; rsp_valid is driven by v_s4, the last of
// the valid registers v_s1, v_s2, v_s3, v_s4 that an accepted item passes through in order
// the pipe has four register stages: decode, index/table add,
// glyph multiply, base add
// arst_n clears valid bits and skid state and sets the config registers to their reset values
// a stalled rsp parks one item in the skid register; req_ready drops until it leaves
module cjk_font_code_address_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  cfau_pkg::req_t                        req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output cfau_pkg::rsp_t                        rsp,
	input  logic                                  cfg_we,
	input  logic [cfau_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cfau_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import cfau_pkg::*;

	cfg_t cfg_q;
	logic pipe_valid;
	rsp_t pipe_rsp;
	logic skid_full_q;
	rsp_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gb2312_mode  <= 1'b0;
			cfg_q.table_base   <= '0;
			cfg_q.glyph_base   <= '0;
			cfg_q.glyph_height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:         cfg_q.gb2312_mode  <= cfg_data[0];
				REG_TABLE_BASE:   cfg_q.table_base   <= cfg_data;
				REG_GLYPH_BASE:   cfg_q.glyph_base   <= cfg_data;
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cfau_addr_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (!skid_full_q),
		.in_valid  (req_valid),
		.in_item   (req),
		.cfg       (cfg_q),
		.out_valid (pipe_valid),
		.out_item  (pipe_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (!skid_full_q && pipe_valid && !rsp_ready) begin
			skid_full_q <= 1'b1;
		end else if (skid_full_q && rsp_ready) begin
			skid_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_q <= pipe_rsp;
		end
	end

	assign req_ready = !skid_full_q;
	assign rsp_valid = skid_full_q || pipe_valid;
	assign rsp       = skid_full_q ? skid_q : pipe_rsp;

endmodule

// ===== rtl/cfau_addr_pipe.sv =====
module cfau_addr_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  cfau_pkg::req_t in_item,
	input  cfau_pkg::cfg_t cfg,
	output logic          out_valid,
	output cfau_pkg::rsp_t out_item
);
	import cfau_pkg::*;

	// stage 1 decode
	logic [7:0]       hi;
	logic [7:0]       lo;
	logic             tab_hit;
	logic [SUB_W-1:0] tab_sub;
	logic             gly_legal;
	logic [7:0]       hi_diff;
	logic [7:0]       lo_diff;
	logic [7:0]       row_len;
	logic [8:0]       ht_sum;
	logic [5:0]       ht_bytes;
	logic [PER_W-1:0] per_glyph;

	logic             v_s1, v_s2, v_s3, v_s4;
	op_t              op_s1, op_s2, op_s3;
	logic             hit_s1, hit_s2, hit_s3;
	logic [15:0]      code_s1;
	logic [SUB_W-1:0] sub_s1;
	logic [6:0]       hi_off_s1;
	logic [7:0]       lo_off_s1;
	logic [7:0]       row_len_s1;
	logic [PER_W-1:0] per_s1, per_s2;
	logic [31:0]      addr_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [31:0]      val_s3;
	rsp_t             rsp_s4;

	assign hi = in_item.code[15:8];
	assign lo = in_item.code[7:0];

	always_comb begin
		tab_hit = 1'b0;
		tab_sub = '0;
		if (cfg.gb2312_mode) begin
			for (int k = 0; k < GB_SPANS; k++) begin
				if (in_item.code >= GB_SPAN_TAB[k].lo && in_item.code <= GB_SPAN_TAB[k].hi) begin
					tab_hit = 1'b1;
					tab_sub = tab_sub | GB_SPAN_TAB[k].sub;
				end
			end
		end else begin
			for (int k = 0; k < GBK_SPANS; k++) begin
				if (in_item.code >= GBK_SPAN_TAB[k].lo && in_item.code <= GBK_SPAN_TAB[k].hi) begin
					tab_hit = 1'b1;
					tab_sub = tab_sub | GBK_SPAN_TAB[k].sub;
				end
			end
		end
	end

	always_comb begin
		if (cfg.gb2312_mode) begin
			gly_legal = (hi >= GB_BYTE_MIN) && (hi <= GB_HI_MAX) &&
				(lo >= GB_BYTE_MIN) && (lo != BYTE_BAD);
			hi_diff   = hi - GB_BYTE_MIN;
			lo_diff   = lo - GB_BYTE_MIN;
			row_len   = GB_ROW_LEN;
		end else begin
			gly_legal = (hi >= GBK_HI_MIN) && (hi != BYTE_BAD) &&
				(lo >= GBK_LO_MIN) && (lo != BYTE_BAD);
			hi_diff   = hi - GBK_HI_MIN;
			lo_diff   = lo - GBK_LO_MIN;
			row_len   = GBK_ROW_LEN;
		end
	end

	// bytes per glyph: ceil(height / 8) * height
	assign ht_sum    = {1'b0, cfg.glyph_height} + 9'd7;
	assign ht_bytes  = ht_sum[8:3];
	assign per_glyph = PER_W'(ht_bytes) * PER_W'(cfg.glyph_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= in_item.opcode;
			hit_s1     <= (in_item.opcode == OP_GLYPH) ? gly_legal : tab_hit;
			code_s1    <= in_item.code;
			sub_s1     <= tab_sub;
			hi_off_s1  <= hi_diff[6:0];
			lo_off_s1  <= lo_diff;
			row_len_s1 <= row_len;
			per_s1     <= per_glyph;

			op_s2   <= op_s1;
			hit_s2  <= hit_s1;
			per_s2  <= per_s1;
			addr_s2 <= cfg.table_base + {15'd0, code_s1, 1'b0} - {15'd0, sub_s1};
			idx_s2  <= IDX_W'(hi_off_s1) * IDX_W'(row_len_s1) + IDX_W'(lo_off_s1);

			op_s3  <= op_s2;
			hit_s3 <= hit_s2;
			if (op_s2 == OP_GLYPH) begin
				val_s3 <= 32'(PROD_W'(per_s2) * PROD_W'(idx_s2));
			end else begin
				val_s3 <= addr_s2;
			end

			rsp_s4.hit <= hit_s3;
			if (!hit_s3) begin
				rsp_s4.byte_address <= '0;
			end else if (op_s3 == OP_GLYPH) begin
				rsp_s4.byte_address <= cfg.glyph_base + GLYPH_HDR + val_s3;
			end else begin
				rsp_s4.byte_address <= val_s3;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_item  = rsp_s4;

endmodule

// ===== rtl/cfau_checker.sv =====
`include "cjk_font_code_address_unit_defines.svh"

module cfau_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input cfau_pkg::rsp_t rsp
);
	import cfau_pkg::*;

	`CFAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`CFAU_ASSERT_IMPL(a_miss_zero, rsp_valid && !rsp.hit, rsp.byte_address == 32'd0)
	`CFAU_ASSERT_IMPL(a_block_has_item, !req_ready, rsp_valid)
	`CFAU_ASSERT_IMPL(a_block_on_stall, $fell(req_ready), $past(rsp_valid && !rsp_ready))

endmodule

bind cjk_font_code_address_unit cfau_checker u_cfau_checker (.*);

// ===== tb/cjk_font_code_address_checker.sv =====
`timescale 1ns / 1ps

module cjk_font_code_address_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  cfau_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  cfau_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [cfau_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfau_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import cfau_pkg::*;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] last;
		logic [31:0] offset;
	} code_range_t;

	localparam code_range_t GBK_RANGES [4] = '{
		'{16'h0000, 16'h047F, 32'd0},
		'{16'h2000, 16'h33FF, 32'd14080},
		'{16'h4E00, 16'h9FFF, 32'd27392},
		'{16'hF900, 16'hFFFF, 32'd68608}
	};

	localparam code_range_t GB2312_RANGES [20] = '{
		'{16'h00A4, 16'h02C9, 32'd328},
		'{16'h0391, 16'h0451, 32'd726},
		'{16'h2014, 16'h203B, 32'd14938},
		'{16'h2103, 16'h2312, 32'd15336},
		'{16'h2460, 16'h2642, 32'd16002},
		'{16'h3000, 16'h3129, 32'd20988},
		'{16'h3220, 16'h3229, 32'd21480},
		'{16'h4E00, 16'h7DAE, 32'd35732},
		'{16'h7E3B, 16'h8C98, 32'd36012},
		'{16'h8D1D, 16'h8ECE, 32'd36276},
		'{16'h8F66, 16'h91DC, 32'd36578},
		'{16'h9274, 16'h99A8, 32'd36880},
		'{16'h9A6C, 16'h9B54, 32'd37270},
		'{16'h9C7C, 16'h9CE2, 32'd37860},
		'{16'h9E1F, 16'h9FA0, 32'd38492},
		'{16'hE000, 16'hE233, 32'd71450},
		'{16'hE766, 16'hE814, 32'd74110},
		'{16'hFE31, 16'hFE44, 32'd85430},
		'{16'hFF01, 16'hFF5E, 32'd85806},
		'{16'hFFE0, 16'hFFFF, 32'd86064}
	};

	localparam logic [31:0] GBK_ROW         = 32'd191;
	localparam logic [31:0] GB2312_ROW      = 32'd94;
	localparam logic [31:0] HEADER_BYTES    = 32'd6;
	localparam logic [7:0]  GBK_LEAD_MIN    = 8'h81;
	localparam logic [7:0]  GBK_TRAIL_MIN   = 8'h40;
	localparam logic [7:0]  GB2312_MIN      = 8'hA1;
	localparam logic [7:0]  GB2312_LEAD_MAX = 8'hF7;
	localparam logic [7:0]  BAD_BYTE        = 8'hFF;
	localparam logic [7:0]  DEFAULT_HEIGHT  = 8'd16;

	logic        mode_gb2312;
	logic [31:0] table_base_q;
	logic [31:0] glyph_base_q;
	logic [7:0]  glyph_height_q;
	rsp_t        address_q [$];
	rsp_t        want;

	function automatic rsp_t lookup_address(input req_t item);
		rsp_t        found;
		code_range_t span;
		logic [7:0]  lead;
		logic [7:0]  trail;
		logic [31:0] index;
		logic [31:0] per_glyph;
		logic        legal;
		found = '0;
		lead  = item.code[15:8];
		trail = item.code[7:0];
		if (item.opcode == OP_TABLE) begin
			for (int k = 0; k < 20; k++) begin
				if (!mode_gb2312 && k >= 4) break;
				span = mode_gb2312 ? GB2312_RANGES[k] : GBK_RANGES[k % 4];
				if (!found.hit && item.code >= span.first && item.code <= span.last) begin
					found.hit          = 1'b1;
					found.byte_address = table_base_q + ({15'd0, item.code, 1'b0} - span.offset);
				end
			end
		end else begin
			per_glyph = (({24'd0, glyph_height_q} + 32'd7) / 32'd8) * {24'd0, glyph_height_q};
			if (mode_gb2312) begin
				legal = lead >= GB2312_MIN && lead <= GB2312_LEAD_MAX &&
					trail >= GB2312_MIN && trail != BAD_BYTE;
				index = {24'd0, 8'(lead - GB2312_MIN)} * GB2312_ROW + {24'd0, 8'(trail - GB2312_MIN)};
			end else begin
				legal = lead >= GBK_LEAD_MIN && lead != BAD_BYTE &&
					trail >= GBK_TRAIL_MIN && trail != BAD_BYTE;
				index = {24'd0, 8'(lead - GBK_LEAD_MIN)} * GBK_ROW + {24'd0, 8'(trail - GBK_TRAIL_MIN)};
			end
			if (legal) begin
				found.hit          = 1'b1;
				found.byte_address = glyph_base_q + HEADER_BYTES + per_glyph * index;
			end
		end
		return found;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_gb2312    <= 1'b0;
			table_base_q   <= '0;
			glyph_base_q   <= '0;
			glyph_height_q <= DEFAULT_HEIGHT;
			address_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (req_valid && req_ready)
				address_q.push_back(lookup_address(req));
			if (rsp_valid && rsp_ready) begin
				if (address_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual hit=%0b byte_address=%h",
						$time, rsp.hit, rsp.byte_address);
					mismatches++;
				end else begin
					want = address_q.pop_front();
					if (rsp.hit !== want.hit) begin
						$display("%0t: hit mismatch, expected %0b, actual %0b",
							$time, want.hit, rsp.hit);
						mismatches++;
					end
					if (rsp.byte_address !== want.byte_address) begin
						$display("%0t: byte_address mismatch, expected %h, actual %h",
							$time, want.byte_address, rsp.byte_address);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:         mode_gb2312    <= cfg_data[0];
					REG_TABLE_BASE:   table_base_q   <= cfg_data;
					REG_GLYPH_BASE:   glyph_base_q   <= cfg_data;
					REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			outstanding = address_q.size();
		end
	end

endmodule

// ===== tb/tb_cjk_font_code_address_unit.sv =====
`timescale 1ns / 1ps

module tb_cjk_font_code_address_unit;
	import cfau_pkg::*;

	localparam int LONG_HOLD      = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 210;
	localparam int TAIL_CYCLES    = 8;

	localparam logic [16:0] GBK_DIRECTED [14] = '{
		{OP_TABLE, 16'h0000}, {OP_TABLE, 16'h047F}, {OP_TABLE, 16'h0480},
		{OP_TABLE, 16'h2000}, {OP_TABLE, 16'h33FF}, {OP_TABLE, 16'h4E00},
		{OP_TABLE, 16'hF8FF}, {OP_TABLE, 16'hFFFF},
		{OP_GLYPH, 16'h8140}, {OP_GLYPH, 16'hFEFE}, {OP_GLYPH, 16'h80FE},
		{OP_GLYPH, 16'hFF40}, {OP_GLYPH, 16'h813F}, {OP_GLYPH, 16'h81FF}
	};

	localparam logic [16:0] GB2312_DIRECTED [10] = '{
		{OP_TABLE, 16'h00A4}, {OP_TABLE, 16'h00A3}, {OP_TABLE, 16'hFFE0},
		{OP_TABLE, 16'h3229},
		{OP_GLYPH, 16'hA1A1}, {OP_GLYPH, 16'hF7FE}, {OP_GLYPH, 16'hF8A1},
		{OP_GLYPH, 16'hA0A1}, {OP_GLYPH, 16'hA1A0}, {OP_GLYPH, 16'hA1FF}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatches;
	int   outstanding;
	int   stall_cycles = 0;
	bit   idle_on = 1'b1;
	bit   long_hold = 1'b0;
	logic cur_mode = 1'b0;

	always #5 clk = ~clk;

	cjk_font_code_address_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cjk_font_code_address_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic logic [7:0] near_bound(input logic [7:0] lo_b, input logic [7:0] hi_b);
		case ($urandom_range(0, 3))
			0:       return lo_b - 8'd1;
			1:       return lo_b;
			2:       return hi_b;
			default: return hi_b + 8'd1;
		endcase
	endfunction

	function automatic req_t random_request();
		req_t        item;
		span_t       span;
		int          k;
		int          sel;
		logic [7:0]  lead;
		logic [7:0]  trail;
		item.opcode = op_t'($urandom_range(0, 1));
		sel = $urandom_range(0, 3);
		if (sel == 0) begin
			item.code = 16'($urandom());
		end else if (item.opcode == OP_TABLE) begin
			k = cur_mode ? $urandom_range(0, GB_SPANS - 1) : $urandom_range(0, GBK_SPANS - 1);
			span = cur_mode ? GB_SPAN_TAB[k] : GBK_SPAN_TAB[k];
			if (sel == 1)
				item.code = 16'($urandom_range(span.lo, span.hi));
			else
				item.code = ($urandom_range(0, 1) ? span.lo : span.hi) +
					16'($urandom_range(0, 4)) - 16'd2;
		end else begin
			if (cur_mode) begin
				lead  = sel == 3 ? near_bound(GB_BYTE_MIN, GB_HI_MAX)
					: 8'($urandom_range(GB_BYTE_MIN, GB_HI_MAX));
				trail = sel == 3 ? near_bound(GB_BYTE_MIN, BYTE_BAD - 8'd1)
					: 8'($urandom_range(GB_BYTE_MIN, BYTE_BAD - 8'd1));
			end else begin
				lead  = sel == 3 ? near_bound(GBK_HI_MIN, BYTE_BAD - 8'd1)
					: 8'($urandom_range(GBK_HI_MIN, BYTE_BAD - 8'd1));
				trail = sel == 3 ? near_bound(GBK_LO_MIN, BYTE_BAD - 8'd1)
					: 8'($urandom_range(GBK_LO_MIN, BYTE_BAD - 8'd1));
			end
			item.code = {lead, trail};
		end
		return item;
	endfunction

	task automatic send_item(input req_t item);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic wait_empty();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic mode, input logic [31:0] tbase, input logic [31:0] gbase,
			input logic [7:0] height, input bit hold, input bit pause, input bit quiet);
		write_reg(REG_MODE, ($urandom() & ~32'd1) | {31'd0, mode});
		write_reg(REG_TABLE_BASE, tbase);
		write_reg(REG_GLYPH_BASE, gbase);
		write_reg(REG_GLYPH_HEIGHT, ($urandom() & 32'hFFFF_FF00) | {24'd0, height});
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_mode = mode;
		idle_on  = !quiet;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == PHASE_ITEMS / 2) begin
				if (hold) long_hold = 1'b1;
				if (pause) wait_empty();
			end
			send_item(random_request());
		end
		wait_empty();
	endtask

	// receiver side
	initial begin
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[cjk_font_code_address_unit] ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, gbk range and code edges
		foreach (GBK_DIRECTED[i]) send_item(req_t'(GBK_DIRECTED[i]));
		wait_empty();
		write_reg(REG_MODE, 32'd1);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_mode = 1'b1;
		foreach (GB2312_DIRECTED[i]) send_item(req_t'(GB2312_DIRECTED[i]));
		wait_empty();

		run_phase(1'b0, 32'd0, 32'd0, 8'd16, 1'b0, 1'b0, 1'b0);
		run_phase(1'b1, $urandom(), $urandom(), 8'($urandom_range(1, 255)), 1'b1, 1'b0, 1'b0);
		run_phase(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b0, 1'b1, 1'b0);
		// zero height collapses every glyph onto the header offset
		run_phase(1'b1, 32'hFFFF_0000, 32'hFFFF_FFF0, 8'd0, 1'b0, 1'b0, 1'b0);
		run_phase(1'b0, $urandom(), $urandom(), 8'd1, 1'b1, 1'b0, 1'b0);
		run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b0, 1'b1, 1'b0);
		run_phase(1'b0, $urandom(), $urandom(), 8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b1);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[cjk_font_code_address_unit] OK");
		else
			$display("[cjk_font_code_address_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfau_pkg.sv
rtl/cfau_addr_pipe.sv
rtl/cjk_font_code_address_unit.sv
rtl/cfau_checker.sv
tb/cjk_font_code_address_checker.sv
tb/tb_cjk_font_code_address_unit.sv
